[src/morse_key_decoder_core_defines.svh]
// Assertion macros used by the morse key decoder top level.
`ifndef MORSE_KEY_DECODER_CORE_DEFINES_SVH
`define MORSE_KEY_DECODER_CORE_DEFINES_SVH
`ifndef SYNTH
// Clocked check, disabled while reset is asserted.
`define MKD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked check that also holds during reset.
`define MKD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MKD_ASSERT(lbl, prop, msg)
`define MKD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[src/mkd_pkg.sv]
// Types, constants and the Morse lookup table of the morse key decoder.
package mkd_pkg;

  localparam int unsigned LetterW  = 14;
  localparam int unsigned TimeW    = 10;
  localparam int unsigned CountW   = 4;
  localparam int unsigned SymBitsW = 8;
  localparam int unsigned CharW    = 7;
  localparam int unsigned EventW   = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  localparam logic [LetterW-1:0] LetterLimitRst = 14'd9000;
  localparam logic [TimeW-1:0]   DotMaxRst      = 10'd250;
  localparam logic [TimeW-1:0]   HoldMaxRst     = 10'd700;
  localparam logic [TimeW-1:0]   GapMinRst      = 10'd400;
  localparam logic [CountW-1:0]  WordLettersRst = 4'd4;

  typedef enum logic [EventW-1:0] {
    EvNone    = 3'd0,
    EvLetter  = 3'd1,
    EvInvalid = 3'd2,
    EvHold    = 3'd3,
    EvTime    = 3'd4
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegLetterLimit = 3'd0,
    RegDotMax      = 3'd1,
    RegHoldMax     = 3'd2,
    RegGapMin      = 3'd3,
    RegWordLetters = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [LetterW-1:0] letter_limit;
    logic [TimeW-1:0]   dot_max;
    logic [TimeW-1:0]   hold_max;
    logic [TimeW-1:0]   gap_min;
    logic [CountW-1:0]  word_letters;
  } cfg_t;

  // Symbol buffer: bit i is symbol i, 1 = dash.
  typedef struct packed {
    logic [SymBitsW-1:0] bits;
    logic [CountW-1:0]   count;
    logic                overflow;
  } sym_t;

  typedef struct packed {
    event_e             event_res;
    logic [CharW-1:0]   letter_code;
    logic               word_done;
    logic [CountW-1:0]  letters_in_word;
  } res_t;

  // International Morse, first symbol in bit 0. Returns 0 for no match.
  function automatic logic [CharW-1:0] morse_char(logic [2:0] len, logic [4:0] code);
    logic [7:0] c;
    c = 8'd0;
    case (len)
      3'd1: begin
        case (code)
          5'd0: c = "E";
          5'd1: c = "T";
          default: c = 8'd0;
        endcase
      end
      3'd2: begin
        case (code)
          5'd0: c = "I";
          5'd1: c = "N";
          5'd2: c = "A";
          5'd3: c = "M";
          default: c = 8'd0;
        endcase
      end
      3'd3: begin
        case (code)
          5'd0: c = "S";
          5'd1: c = "D";
          5'd2: c = "R";
          5'd3: c = "G";
          5'd4: c = "U";
          5'd5: c = "K";
          5'd6: c = "W";
          5'd7: c = "O";
          default: c = 8'd0;
        endcase
      end
      3'd4: begin
        case (code)
          5'd0:  c = "H";
          5'd1:  c = "B";
          5'd2:  c = "L";
          5'd3:  c = "Z";
          5'd4:  c = "F";
          5'd5:  c = "C";
          5'd6:  c = "P";
          5'd8:  c = "V";
          5'd9:  c = "X";
          5'd11: c = "Q";
          5'd13: c = "Y";
          5'd14: c = "J";
          default: c = 8'd0;
        endcase
      end
      3'd5: begin
        case (code)
          5'd0:  c = "5";
          5'd1:  c = "6";
          5'd3:  c = "7";
          5'd7:  c = "8";
          5'd15: c = "9";
          5'd16: c = "4";
          5'd24: c = "3";
          5'd28: c = "2";
          5'd30: c = "1";
          5'd31: c = "0";
          default: c = 8'd0;
        endcase
      end
      default: c = 8'd0;
    endcase
    return c[CharW-1:0];
  endfunction

endpackage

[src/mkd_key_if.sv]
// Input channel: one key sample per request.
interface mkd_key_if;
  logic valid;
  logic ready;
  logic key_down;

  modport source(output valid, output key_down, input ready);
  modport sink(input valid, input key_down, output ready);
endinterface

[src/mkd_res_if.sv]
// Result channel: one decode result per request.
interface mkd_res_if;
  logic                            valid;
  logic                            ready;
  logic [mkd_pkg::EventW-1:0]      event_res;
  logic [mkd_pkg::CharW-1:0]       letter_code;
  logic                            word_done;
  logic [mkd_pkg::CountW-1:0]      letters_in_word;

  modport source(output valid, output event_res, output letter_code, output word_done,
                 output letters_in_word, input ready);
  modport sink(input valid, input event_res, input letter_code, input word_done,
               input letters_in_word, output ready);
endinterface

[src/mkd_lookup.sv]
// Symbol buffer to ASCII decode.
module mkd_lookup (
  input  mkd_pkg::sym_t                 sym_i,
  output logic [mkd_pkg::CharW-1:0]     char_o
);
  import mkd_pkg::*;

  // Codes longer than five symbols, or overflowed, have no letter.
  always_comb begin
    if (sym_i.overflow || (sym_i.count > 4'd5)) begin
      char_o = '0;
    end else begin
      char_o = morse_char(sym_i.count[2:0], sym_i.bits[4:0]);
    end
  end
endmodule

[src/mkd_fsm.sv]
// Key timing state machine: press, gap and letter timers, symbol buffer, word count.
module mkd_fsm #(
  parameter int unsigned MAX_SYMBOLS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          key_i,
  input  mkd_pkg::cfg_t cfg_i,
  output mkd_pkg::res_t res_o
);
  import mkd_pkg::*;

  localparam logic [CountW-1:0] SymLimit =
    (MAX_SYMBOLS < 15) ? CountW'(MAX_SYMBOLS) : 4'd15;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhPress = 2'd1,
    PhGap   = 2'd2,
    PhLock  = 2'd3
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [TimeW-1:0]   press_q, press_d;
  logic [TimeW-1:0]   gap_q, gap_d;
  logic [LetterW-1:0] letter_q, letter_d;
  sym_t               sym_q, sym_d;
  logic [CountW-1:0]  word_q, word_d;

  logic [LetterW-1:0] letter_inc;
  logic [TimeW-1:0]   press_inc;
  logic [TimeW-1:0]   gap_inc;
  logic [CountW-1:0]  word_inc;
  logic [CountW-1:0]  target;
  logic [CharW-1:0]   char;
  logic               dash;

  mkd_lookup u_lookup (
    .sym_i  (sym_q),
    .char_o (char)
  );

  // Saturating counters.
  assign letter_inc = (letter_q == '1) ? letter_q : letter_q + 1'b1;
  assign press_inc  = (press_q == '1) ? press_q : press_q + 1'b1;
  assign gap_inc    = (gap_q == '1) ? gap_q : gap_q + 1'b1;
  assign word_inc   = (word_q == '1) ? word_q : word_q + 1'b1;
  assign target     = (cfg_i.word_letters == '0) ? 4'd1 : cfg_i.word_letters;
  assign dash       = (press_q >= cfg_i.dot_max);

  always_comb begin
    phase_d  = phase_q;
    press_d  = press_q;
    gap_d    = gap_q;
    letter_d = letter_inc;
    sym_d    = sym_q;
    word_d   = word_q;
    res_o.event_res       = EvNone;
    res_o.letter_code     = '0;
    res_o.word_done       = 1'b0;
    res_o.letters_in_word = word_q;

    if (letter_inc > cfg_i.letter_limit) begin
      // letter time limit: drop the symbol buffer and letter timer, including a press in progress
      res_o.event_res = EvTime;
      letter_d = '0;
      sym_d    = '0;
      phase_d  = key_i ? PhLock : PhIdle;
    end else begin
      case (phase_q)
        PhLock: begin
          if (!key_i) phase_d = PhIdle;
        end
        PhPress: begin
          if (key_i) begin
            press_d = press_inc;
            if (press_inc >= cfg_i.hold_max) begin
              res_o.event_res = EvHold;
              letter_d = '0;
              sym_d    = '0;
              phase_d  = PhLock;
            end
          end else begin
            if (sym_q.count >= SymLimit) begin
              sym_d.overflow = 1'b1;
            end else begin
              if ((sym_q.count < 4'd8) && dash) sym_d.bits[sym_q.count[2:0]] = 1'b1;
              sym_d.count = sym_q.count + 1'b1;
            end
            gap_d   = '0;
            phase_d = PhGap;
          end
        end
        default: begin
          // idle or gap
          if (key_i) begin
            press_d = TimeW'(1);
            phase_d = PhPress;
            if (TimeW'(1) >= cfg_i.hold_max) begin
              res_o.event_res = EvHold;
              letter_d = '0;
              sym_d    = '0;
              phase_d  = PhLock;
            end
          end else if (phase_q == PhGap) begin
            gap_d = gap_inc;
            if (gap_inc > cfg_i.gap_min) begin
              if ((sym_q.count != '0) || sym_q.overflow) begin
                if (char != '0) begin
                  res_o.event_res       = EvLetter;
                  res_o.letter_code     = char;
                  res_o.letters_in_word = word_inc;
                  res_o.word_done       = (word_inc >= target);
                  word_d = (word_inc >= target) ? '0 : word_inc;
                end else begin
                  res_o.event_res = EvInvalid;
                end
              end
              letter_d = '0;
              sym_d    = '0;
              phase_d  = PhIdle;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      press_q  <= '0;
      gap_q    <= '0;
      letter_q <= '0;
      sym_q    <= '0;
      word_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      press_q  <= press_d;
      gap_q    <= gap_d;
      letter_q <= letter_d;
      sym_q    <= sym_d;
      word_q   <= word_d;
    end
  end
endmodule

[src/morse_key_decoder_core.sv]
// Top level of the morse key decoder: channels, registers, input and result stages.
//
// Usage:
//   key_i carries one key sample per millisecond tick (key_down = 1 pressed).
//   res_o returns exactly one result request per accepted tick: event_res
//   (none, letter, invalid code, hold too long, time limit), letter_code
//   (ASCII on a letter, else 0), word_done and letters_in_word. The user must
//   write timing registers via cfg_we_i / cfg_idx_i / cfg_wdata_i only while the
//   block is idle (not enforced); indexes past the register list are ignored.
// Pipeline and rate:
//   A tick accepted into the input register is decoded and timed from there,
//   and its result is captured in the result register. One tick per cycle is
//   sustained while res_o.ready stays high; the state update is a single pass
//   of saturating counters plus the 36-entry code table.
// Reset:
//   rst_ni clears timers, the symbol buffer and the word count, loads the
//   default register values and empties both stages.
// Stall:
//   When res_o.ready is low, the result stays in its register and one more
//   tick can wait in the input register; key_i.ready drops after that.
`include "morse_key_decoder_core_defines.svh"
module morse_key_decoder_core #(
  parameter int unsigned MAX_SYMBOLS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mkd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mkd_pkg::CfgDataW-1:0]     cfg_wdata_i,
  mkd_key_if.sink                          key_i,
  mkd_res_if.source                        res_o
);
  import mkd_pkg::*;

  cfg_t cfg_q;

  // input register
  logic in_valid_q;
  logic key_q;

  // result register
  logic out_valid_q;
  res_t res_q;
  res_t res;

  logic advance;
  logic step;

  // result register free or being drained this cycle
  assign advance     = !out_valid_q || res_o.ready;
  assign step        = in_valid_q && advance;
  assign key_i.ready = !in_valid_q || advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.letter_limit <= LetterLimitRst;
      cfg_q.dot_max      <= DotMaxRst;
      cfg_q.hold_max     <= HoldMaxRst;
      cfg_q.gap_min      <= GapMinRst;
      cfg_q.word_letters <= WordLettersRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegLetterLimit: cfg_q.letter_limit <= cfg_wdata_i[LetterW-1:0];
        RegDotMax:      cfg_q.dot_max      <= cfg_wdata_i[TimeW-1:0];
        RegHoldMax:     cfg_q.hold_max     <= cfg_wdata_i[TimeW-1:0];
        RegGapMin:      cfg_q.gap_min      <= cfg_wdata_i[TimeW-1:0];
        RegWordLetters: cfg_q.word_letters <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (key_i.ready) begin
      in_valid_q <= key_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_i.valid && key_i.ready) key_q <= key_i.key_down;
  end

  mkd_fsm #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .key_i  (key_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res;
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.event_res       = res_q.event_res;
  assign res_o.letter_code     = res_q.letter_code;
  assign res_o.word_done       = res_q.word_done;
  assign res_o.letters_in_word = res_q.letters_in_word;

  // a waiting tick is kept until the result register frees up
  `MKD_ASSERT(a_hold_pending, in_valid_q && !advance |=> in_valid_q && $stable(key_q), "pending tick lost")
  // a letter always carries a character
  `MKD_ASSERT(a_letter_char, res_o.valid && res_o.event_res == EvLetter |-> res_o.letter_code != '0, "letter without code")
  // code and word flag only come with a letter
  `MKD_ASSERT(a_no_letter, res_o.valid && res_o.event_res != EvLetter |-> res_o.letter_code == '0 && !res_o.word_done, "code outside letter")
  // a completed word has at least one letter
  `MKD_ASSERT(a_word_count, res_o.valid && res_o.word_done |-> res_o.letters_in_word != '0, "empty word done")
  // nothing is presented while in reset
  `MKD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !res_o.valid, "result valid in reset")
endmodule
